>>> hw/rtl/msb_first_bit_unpacker_core_defines.svh
// ----------------------------------------------------------------------------
// MSB-first bit unpacker: assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef MSB_FIRST_BIT_UNPACKER_CORE_DEFINES_SVH
`define MSB_FIRST_BIT_UNPACKER_CORE_DEFINES_SVH

// Same-cycle implication: whenever ANTE holds, CONS holds too.
`define MFBU_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mfbu assertion failed");

// Next-cycle implication: whenever ANTE holds, CONS holds in the next cycle.
`define MFBU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mfbu assertion failed");

`endif

>>> hw/rtl/mfbu_pkg.sv
// ----------------------------------------------------------------------------
// MSB-first bit unpacker: package
// Command and status codes, and the structs passed between modules.
// ----------------------------------------------------------------------------
package mfbu_pkg;

    typedef enum logic [2:0] {
        CMD_PUSH      = 3'd0,
        CMD_MARK_END  = 3'd1,
        CMD_READ_U    = 3'd2,
        CMD_READ_S    = 3'd3,
        CMD_ALIGN     = 3'd4,
        CMD_ALIGNED_U = 3'd5,
        CMD_ALIGNED_S = 3'd6,
        CMD_SKIP      = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_END      = 2'd1,
        ST_UNDERRUN = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    // Fixed-width stream state
    typedef struct packed {
        logic        stream_ended;
        logic        sticky_end;
        logic [31:0] skip_debt;
        logic [31:0] consumed_bits;
    } ctrl_t;

    typedef struct packed {
        logic [31:0] value;
        status_t     status;
    } result_t;

endpackage

>>> hw/rtl/mfbu_step.sv
// ----------------------------------------------------------------------------
// MSB-first bit unpacker: step logic
// Next state and result for one item; one left shifter on the buffer.
// ----------------------------------------------------------------------------
module mfbu_step #(
    parameter int BUFFER_BITS = 64,
    localparam int FILL_W = $clog2(BUFFER_BITS + 1)
) (
    input  mfbu_pkg::cmd_t          command,
    input  logic [7:0]              data_byte,
    input  logic [5:0]              bit_count,
    input  logic [2:0]              byte_count,
    input  logic [31:0]             skip_bits,
    input  logic [BUFFER_BITS-1:0]  bits_cur,
    input  logic [FILL_W-1:0]       fill_cur,
    input  mfbu_pkg::ctrl_t         ctrl_cur,
    output logic [BUFFER_BITS-1:0]  bits_nxt,
    output logic [FILL_W-1:0]       fill_nxt,
    output mfbu_pkg::ctrl_t         ctrl_nxt,
    output mfbu_pkg::result_t       result
);
    import mfbu_pkg::*;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    logic [31:0]             fill32;
    logic [5:0]              nb;
    logic [5:0]              sh_rd;
    logic [2:0]              pad;
    logic [2:0]              t_al;
    logic [2:0]              rest_al;
    logic [39:0]             win;
    logic [39:0]             win_al;
    logic [31:0]             top_al;
    logic [31:0]             rd_u;
    logic signed [31:0]      rd_s;
    logic [31:0]             al_u;
    logic [31:0]             al_s;
    logic                    bc_legal;
    logic [5:0]              al_bits;
    logic [5:0]              need_al;
    logic [3:0]              drop_push;
    logic [3:0]              keep;
    logic                    push_fits;
    logic [7:0]              byte_sh;
    logic [BUFFER_BITS-1:0]  ins;
    logic [31:0]             t_sk;
    logic [31:0]             rest_sk;
    logic [FILL_W-1:0]       drop_amt;
    logic                    push_ok;
    logic                    short_rd;

    // Operand preparation
    always_comb begin
        fill32   = 32'(fill_cur);
        nb       = (bit_count > 6'd32) ? 6'd32 : bit_count;
        sh_rd    = 6'd32 - nb;
        pad      = 3'd0 - ctrl_cur.consumed_bits[2:0];
        t_al     = (FILL_W'(pad) < fill_cur) ? pad : fill_cur[2:0];
        rest_al  = pad - t_al;

        // Oldest bits sit at the top of the buffer
        win      = bits_cur[BUFFER_BITS-1 -: 40];
        win_al   = win << pad;
        top_al   = win_al[39:8];
        rd_u     = win[39:8] >> sh_rd;
        rd_s     = $signed(win[39:8]) >>> sh_rd;

        bc_legal = (byte_count == 3'd1) || (byte_count == 3'd2) || (byte_count == 3'd4);
        al_bits  = {byte_count, 3'b000};
        need_al  = 6'(pad) + al_bits;
        // Little-endian byte order: first byte lands in the low bits
        unique case (byte_count)
            3'd1: begin
                al_u = {24'd0, top_al[31:24]};
                al_s = {{24{top_al[31]}}, top_al[31:24]};
            end
            3'd2: begin
                al_u = {16'd0, top_al[23:16], top_al[31:24]};
                al_s = {{16{top_al[23]}}, top_al[23:16], top_al[31:24]};
            end
            default: begin
                al_u = {top_al[7:0], top_al[15:8], top_al[23:16], top_al[31:24]};
                al_s = al_u;
            end
        endcase

        drop_push = (ctrl_cur.skip_debt < 32'd8) ? ctrl_cur.skip_debt[3:0] : 4'd8;
        keep      = 4'd8 - drop_push;
        push_fits = (fill32 + 32'(keep)) <= 32'(BUFFER_BITS);
        byte_sh   = data_byte << drop_push;
        ins       = {byte_sh, {(BUFFER_BITS-8){1'b0}}} >> fill_cur;

        t_sk      = (skip_bits < fill32) ? skip_bits : fill32;
        rest_sk   = skip_bits - t_sk;
    end

    // Command decode and state update
    always_comb begin
        ctrl_nxt      = ctrl_cur;
        result.value  = 32'd0;
        result.status = ST_OK;
        drop_amt      = '0;
        push_ok       = 1'b0;
        short_rd      = 1'b0;

        unique case (command)
            CMD_PUSH: begin
                if (push_fits) begin
                    push_ok            = 1'b1;
                    ctrl_nxt.skip_debt = ctrl_cur.skip_debt - 32'(drop_push);
                end else begin
                    result.status = ST_OVERFLOW;
                end
            end
            CMD_MARK_END: begin
                ctrl_nxt.stream_ended = 1'b1;
            end
            CMD_READ_U, CMD_READ_S: begin
                if (nb != 6'd0) begin
                    if ((ctrl_cur.skip_debt == 32'd0) && (fill32 >= 32'(nb))) begin
                        result.value = (command == CMD_READ_S) ? 32'(rd_s) : rd_u;
                        drop_amt     = FILL_W'(nb);
                        ctrl_nxt.consumed_bits = ctrl_cur.consumed_bits + 32'(nb);
                    end else begin
                        short_rd = 1'b1;
                    end
                end
            end
            CMD_ALIGNED_U, CMD_ALIGNED_S: begin
                if (!bc_legal) begin
                    drop_amt = FILL_W'(t_al);
                    ctrl_nxt.consumed_bits = ctrl_cur.consumed_bits + 32'(pad);
                    ctrl_nxt.skip_debt     = sat_add(ctrl_cur.skip_debt, 32'(rest_al));
                end else if ((ctrl_cur.skip_debt == 32'd0) && (fill32 >= 32'(need_al))) begin
                    result.value = (command == CMD_ALIGNED_S) ? al_s : al_u;
                    drop_amt     = FILL_W'(need_al);
                    ctrl_nxt.consumed_bits = ctrl_cur.consumed_bits + 32'(need_al);
                end else begin
                    short_rd = 1'b1;
                end
            end
            CMD_ALIGN: begin
                drop_amt = FILL_W'(t_al);
                ctrl_nxt.consumed_bits = ctrl_cur.consumed_bits + 32'(pad);
                ctrl_nxt.skip_debt     = sat_add(ctrl_cur.skip_debt, 32'(rest_al));
            end
            CMD_SKIP: begin
                drop_amt = FILL_W'(t_sk);
                ctrl_nxt.consumed_bits = ctrl_cur.consumed_bits + skip_bits;
                ctrl_nxt.skip_debt     = sat_add(ctrl_cur.skip_debt, rest_sk);
            end
        endcase

        // Too few bits: flush everything once the end is marked
        if (short_rd) begin
            if (ctrl_cur.stream_ended) begin
                ctrl_nxt.sticky_end    = 1'b1;
                drop_amt               = fill_cur;
                ctrl_nxt.consumed_bits = ctrl_cur.consumed_bits + fill32;
                result.status          = ST_END;
            end else begin
                result.status = ST_UNDERRUN;
            end
        end

        if (push_ok) begin
            bits_nxt = bits_cur | ins;
            fill_nxt = fill_cur + FILL_W'(keep);
        end else begin
            bits_nxt = bits_cur << drop_amt;
            fill_nxt = fill_cur - drop_amt;
        end
    end

endmodule

>>> hw/rtl/msb_first_bit_unpacker_core.sv
// ----------------------------------------------------------------------------
// MSB-first bit unpacker core
// Bit-field reader over a pushed byte stream, one command item per cycle while results are not stalled.
// ----------------------------------------------------------------------------
//  Channel  | Ports                                   | Carries
//  ---------+-----------------------------------------+---------------------------
//  input    | s_valid/s_ready, s_command, s_data_byte, | one command item
//           | s_bit_count, s_byte_count, s_skip_bits   |
//  result   | m_valid/m_ready, m_value, m_status,      | one result item per
//           | m_end_flag, m_bit_position               | command item
//
//  Each item passes from acceptance into the input register, then through
//  the step logic into the result register.
//  Sustained rate is one item per cycle while the result channel does not
//  stall, set by the buffer shifters between the state registers and their next values.
//  A stalled result register holds the input register; the input register
//  still refills in the cycle its item moves on.
//  aresetn (synchronous, active low) empties the buffer and clears the stream state and valid flags.
// ----------------------------------------------------------------------------
`include "msb_first_bit_unpacker_core_defines.svh"

module msb_first_bit_unpacker_core #(
    parameter int BUFFER_BITS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [7:0]  s_data_byte,
    input  logic [5:0]  s_bit_count,
    input  logic [2:0]  s_byte_count,
    input  logic [31:0] s_skip_bits,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_value,
    output logic [1:0]  m_status,
    output logic        m_end_flag,
    output logic [31:0] m_bit_position
);
    import mfbu_pkg::*;

    localparam int FILL_W = $clog2(BUFFER_BITS + 1);

    // Input register
    logic        in_valid_reg;
    cmd_t        cmd_reg;
    logic [7:0]  byte_reg;
    logic [5:0]  nbits_reg;
    logic [2:0]  nbytes_reg;
    logic [31:0] skip_reg;

    // Stream state: buffer is left-aligned, oldest bit at the top,
    // and everything below the fill level is kept at zero.
    logic [BUFFER_BITS-1:0] bits_reg;
    logic [BUFFER_BITS-1:0] bits_next;
    logic [FILL_W-1:0]      fill_reg;
    logic [FILL_W-1:0]      fill_next;
    ctrl_t                  ctrl_reg;
    ctrl_t                  ctrl_next;
    result_t                result;

    // Result register
    logic        out_valid_reg;
    logic [31:0] value_reg;
    status_t     status_reg;
    logic        end_flag_reg;
    logic [31:0] position_reg;

    // Item in the input register moves on when the result slot is free
    logic advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Payload capture, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg    <= cmd_t'(s_command);
            byte_reg   <= s_data_byte;
            nbits_reg  <= s_bit_count;
            nbytes_reg <= s_byte_count;
            skip_reg   <= s_skip_bits;
        end
    end

    mfbu_step #(
        .BUFFER_BITS (BUFFER_BITS)
    ) u_step (
        .command    (cmd_reg),
        .data_byte  (byte_reg),
        .bit_count  (nbits_reg),
        .byte_count (nbytes_reg),
        .skip_bits  (skip_reg),
        .bits_cur   (bits_reg),
        .fill_cur   (fill_reg),
        .ctrl_cur   (ctrl_reg),
        .bits_nxt   (bits_next),
        .fill_nxt   (fill_next),
        .ctrl_nxt   (ctrl_next),
        .result     (result)
    );

    // State commits only as the item's result is written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_reg <= '0;
            fill_reg <= '0;
            ctrl_reg <= '0;
        end else if (advance) begin
            bits_reg <= bits_next;
            fill_reg <= fill_next;
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // End flag and position report the state after the item
    always_ff @(posedge aclk) begin
        if (advance) begin
            value_reg    <= result.value;
            status_reg   <= result.status;
            end_flag_reg <= ctrl_next.sticky_end;
            position_reg <= ctrl_next.consumed_bits;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_value        = value_reg;
    assign m_status       = status_reg;
    assign m_end_flag     = end_flag_reg;
    assign m_bit_position = position_reg;

    // Assertions
    `MFBU_ASSERT_IMPL(a_fill_range, aclk, aresetn, 1'b1, 32'(fill_reg) <= 32'(BUFFER_BITS))
    `MFBU_ASSERT_IMPL(a_debt_empty, aclk, aresetn, ctrl_reg.skip_debt != 32'd0, fill_reg == '0)
    `MFBU_ASSERT_IMPL(a_sticky_needs_mark, aclk, aresetn, ctrl_reg.sticky_end, ctrl_reg.stream_ended)
    `MFBU_ASSERT_IMPL(a_fail_zero, aclk, aresetn, m_valid && (m_status != ST_OK), m_value == 32'd0)
    `MFBU_ASSERT_IMPL(a_end_flagged, aclk, aresetn, m_valid && (m_status == ST_END), m_end_flag)

endmodule
